[rtl/b512_pkg.sv]
package b512_pkg;

  typedef logic [63:0] word_t;
  typedef logic [3:0][63:0] row_t;

  localparam int unsigned WordW   = 64;
  localparam int unsigned MsgWords = 16;

  // Compression modes.
  localparam logic [1:0] ModeNormal = 2'd0;
  localparam logic [1:0] ModeFinal  = 2'd1;
  localparam logic [1:0] ModeTail   = 2'd2;

  localparam logic [127:0] BlockBits = 128'd1024;

  localparam logic [7:0][63:0] Iv = {
    64'h5BE0CD19137E2179, 64'h1F83D9ABFB41BD6B,
    64'h9B05688C2B3E6C1F, 64'h510E527FADE682D1,
    64'hA54FF53A5F1D36F1, 64'h3C6EF372FE94F82B,
    64'hBB67AE8584CAA73B, 64'h6A09E667F3BCC908
  };

  localparam logic [15:0][63:0] Pi = {
    64'h636920D871574E69, 64'h0801F2E2858EFC16,
    64'h24A19947B3916CF7, 64'hBA7C9045F12C7F99,
    64'hB8E1AFED6A267E96, 64'h2FFD72DBD01ADFB7,
    64'hD1310BA698DFB5AC, 64'h9216D5D98979FB1B,
    64'h3F84D5B5B5470917, 64'hC0AC29B7C97C50DD,
    64'hBE5466CF34E90C6C, 64'h452821E638D01377,
    64'h082EFA98EC4E6C89, 64'hA4093822299F31D0,
    64'h13198A2E03707344, 64'h243F6A8885A308D3
  };

  localparam logic [3:0] Sigma [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  // Control of the shared mixing unit for one half step.
  typedef struct packed {
    logic half;
  } g_ctrl_t;

  function automatic word_t bswap(input word_t x);
    word_t y;
    for (int i = 0; i < 8; i++) begin
      y[8*i +: 8] = x[8*(7-i) +: 8];
    end
    return y;
  endfunction

  // Keeps the top n bits of the partial byte and sets the bit just below.
  function automatic logic [7:0] marker_byte(input logic [7:0] ub, input logic [2:0] n);
    logic [7:0] z;
    logic [7:0] keep;
    z    = 8'h80 >> n;
    keep = 8'(9'h100 - {1'b0, z});
    return (ub & keep) | z;
  endfunction

  function automatic row_t rot_row(input row_t x, input logic [1:0] r);
    row_t y;
    for (int j = 0; j < 4; j++) begin
      y[j] = x[2'(j) + r];
    end
    return y;
  endfunction

endpackage

[rtl/b512_ram.sv]
module b512_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/b512_g_unit.sv]
module b512_g_unit (
  input  b512_pkg::g_ctrl_t ctrl_i,
  input  b512_pkg::word_t   a_i,
  input  b512_pkg::word_t   b_i,
  input  b512_pkg::word_t   c_i,
  input  b512_pkg::word_t   d_i,
  input  b512_pkg::word_t   mx_i,
  output b512_pkg::word_t   a_o,
  output b512_pkg::word_t   b_o,
  output b512_pkg::word_t   c_o,
  output b512_pkg::word_t   d_o
);
  import b512_pkg::*;

  word_t a1, d_x, d1, c1, b_x, b1;

  // One half of G: the first half rotates by 32 and 25, the second by 16 and 11.
  always_comb begin
    a1  = a_i + b_i + mx_i;
    d_x = d_i ^ a1;
    d1  = ctrl_i.half ? {d_x[15:0], d_x[63:16]} : {d_x[31:0], d_x[63:32]};
    c1  = c_i + d1;
    b_x = b_i ^ c1;
    b1  = ctrl_i.half ? {b_x[10:0], b_x[63:11]} : {b_x[24:0], b_x[63:25]};
  end

  assign a_o = a1;
  assign b_o = b1;
  assign c_o = c1;
  assign d_o = d1;

endmodule

[rtl/blake512_hash_engine_top.sv]
// BLAKE-512 engine for one message. Message words are taken while the engine
// is idle; a word with cmd_i low is byte-swapped into a 16-entry block buffer,
// and the sixteenth word starts a compression. A word with cmd_i high pads the
// message (marker byte with up to seven trailing bits, the 0x01 bit and the
// 128-bit length), compresses the final block, and a second one if 14 or 15
// words were pending, then delivers eight digest words, word_index_o 0 to 7,
// with last_o on the eighth. A single half-G mixing unit is reused for every
// step: one compression runs a load step, the mixing steps (16 rounds of 8 G
// functions, two halves each) and a feed-forward step, during which in_ready_o
// stays low. Words that complete no block leave the engine idle. After the
// last digest word the engine returns to the initial value.
module blake512_hash_engine_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   cmd_i,
  input  logic [63:0]            msg_word_i,
  input  logic [7:0]             extra_bits_i,
  input  logic [2:0]             extra_bit_count_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [63:0]            digest_word_o,
  output logic [2:0]             word_index_o,
  output logic                   last_o
);
  import b512_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLoad = 3'd1;
  localparam logic [2:0] StRun  = 3'd2;
  localparam logic [2:0] StFin  = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [1:0]       mode_q, mode_d;
  logic [3:0]       wc_q, wc_d;
  logic [127:0]     cnt_q, cnt_d;
  logic [127:0]     len_q, len_d;
  logic             nobits_q, nobits_d;
  logic [7:0]       marker_q, marker_d;
  logic [7:0]       step_q, step_d;
  logic [3:0]       midx_q;
  logic [2:0]       oidx_q, oidx_d;
  logic [7:0][63:0] h_q, h_d;
  row_t             va_q, vb_q, vc_q, vd_q;
  row_t             va_d, vb_d, vc_d, vd_d;

  logic             in_fire, out_fire;
  logic [7:0]       nstep;
  logic [3:0]       nrnd, rnd;
  logic [3:0]       raddr;
  word_t            rdata, mword, mx;
  word_t            ga, gb, gc, gd;
  g_ctrl_t          gctrl;
  logic [2:0]       gsel;
  logic [1:0]       rot_b, rot_c, rot_d;
  logic [9:0]       bits;
  logic [127:0]     clen;
  row_t             ra, rb, rc, rd;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StEmit);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  // The buffer is read ahead of each step so its registered data meets the step.
  assign nstep = (state_q == StRun) ? step_q + 8'd1 : 8'd0;
  assign nrnd  = (nstep[7:4] >= 4'd10) ? nstep[7:4] - 4'd10 : nstep[7:4];
  assign raddr = Sigma[nrnd][nstep[3:0]];
  assign rnd   = (step_q[7:4] >= 4'd10) ? step_q[7:4] - 4'd10 : step_q[7:4];

  always_ff @(posedge clk_i) begin
    midx_q <= raddr;
  end

  b512_ram #(
    .Width (WordW),
    .Depth (MsgWords)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (in_fire && !cmd_i),
    .waddr_i (wc_q),
    .wdata_i (bswap(msg_word_i)),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Message word of the current step; padding words are formed here and
  // never come from the buffer.
  always_comb begin
    case (mode_q)
      ModeFinal: begin
        if (midx_q < wc_q) begin
          mword = rdata;
        end else if (midx_q == wc_q) begin
          mword = {marker_q, 56'd0};
        end else begin
          mword = '0;
        end
        if (wc_q <= 4'd13) begin
          if (midx_q == 4'd13) mword = mword | 64'd1;
          if (midx_q == 4'd14) mword = len_q[127:64];
          if (midx_q == 4'd15) mword = len_q[63:0];
        end
      end
      ModeTail: begin
        if (midx_q == 4'd13) begin
          mword = 64'd1;
        end else if (midx_q == 4'd14) begin
          mword = len_q[127:64];
        end else if (midx_q == 4'd15) begin
          mword = len_q[63:0];
        end else begin
          mword = '0;
        end
      end
      default: mword = rdata;
    endcase
  end

  assign mx         = mword ^ Pi[Sigma[rnd][{step_q[3:1], ~step_q[0]}]];
  assign gctrl.half = step_q[0];
  assign gsel       = step_q[3:1];

  b512_g_unit u_g (
    .ctrl_i (gctrl),
    .a_i    (va_q[0]),
    .b_i    (vb_q[0]),
    .c_i    (vc_q[0]),
    .d_i    (vd_q[0]),
    .mx_i   (mx),
    .a_o    (ga),
    .b_o    (gb),
    .c_o    (gc),
    .d_o    (gd)
  );

  // The rows turn after each G so the next column or diagonal sits at place
  // zero; the extra turns after G3 and G7 switch between columns and diagonals.
  always_comb begin
    case (gsel)
      3'd3: begin
        rot_b = 2'd2;
        rot_c = 2'd3;
        rot_d = 2'd0;
      end
      3'd7: begin
        rot_b = 2'd0;
        rot_c = 2'd3;
        rot_d = 2'd2;
      end
      default: begin
        rot_b = 2'd1;
        rot_c = 2'd1;
        rot_d = 2'd1;
      end
    endcase
  end

  always_comb begin
    ra = va_q;
    rb = vb_q;
    rc = vc_q;
    rd = vd_q;
    ra[0] = ga;
    rb[0] = gb;
    rc[0] = gc;
    rd[0] = gd;
  end

  assign bits = {wc_q, 6'd0} + {7'd0, extra_bit_count_i};

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    wc_d     = wc_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    nobits_d = nobits_q;
    marker_d = marker_q;
    step_d   = step_q;
    oidx_d   = oidx_q;
    h_d      = h_q;
    va_d     = va_q;
    vb_d     = vb_q;
    vc_d     = vc_q;
    vd_d     = vd_q;
    clen     = '0;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (!cmd_i) begin
            wc_d = wc_q + 4'd1;
            if (wc_q == 4'd15) begin
              cnt_d   = cnt_q + BlockBits;
              mode_d  = ModeNormal;
              state_d = StLoad;
            end
          end else begin
            len_d    = cnt_q + {118'd0, bits};
            nobits_d = (bits == 10'd0);
            marker_d = marker_byte(extra_bits_i, extra_bit_count_i);
            mode_d   = ModeFinal;
            state_d  = StLoad;
          end
        end
      end
      StLoad: begin
        case (mode_q)
          ModeFinal: clen = nobits_q ? '0 : len_q;
          ModeTail:  clen = '0;
          default:   clen = cnt_q;
        endcase
        va_d    = h_q[3:0];
        vb_d    = h_q[7:4];
        vc_d    = Pi[3:0];
        vd_d    = {clen[127:64] ^ Pi[7], clen[127:64] ^ Pi[6],
                   clen[63:0] ^ Pi[5], clen[63:0] ^ Pi[4]};
        step_d  = '0;
        state_d = StRun;
      end
      StRun: begin
        if (step_q[0]) begin
          va_d = rot_row(ra, 2'd1);
          vb_d = rot_row(rb, rot_b);
          vc_d = rot_row(rc, rot_c);
          vd_d = rot_row(rd, rot_d);
        end else begin
          va_d = ra;
          vb_d = rb;
          vc_d = rc;
          vd_d = rd;
        end
        step_d = step_q + 8'd1;
        if (step_q == 8'hFF) begin
          state_d = StFin;
        end
      end
      StFin: begin
        for (int i = 0; i < 4; i++) begin
          h_d[i]     = h_q[i] ^ va_q[i] ^ vc_q[i];
          h_d[i + 4] = h_q[i + 4] ^ vb_q[i] ^ vd_q[i];
        end
        oidx_d = '0;
        if (mode_q == ModeNormal) begin
          state_d = StIdle;
        end else if (mode_q == ModeFinal && wc_q >= 4'd14) begin
          mode_d  = ModeTail;
          state_d = StLoad;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_fire) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            h_d     = Iv;
            wc_d    = '0;
            cnt_d   = '0;
            mode_d  = ModeNormal;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mode_q  <= ModeNormal;
      wc_q    <= '0;
      cnt_q   <= '0;
      step_q  <= '0;
      oidx_q  <= '0;
      h_q     <= Iv;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      wc_q    <= wc_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      oidx_q  <= oidx_d;
      h_q     <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    nobits_q <= nobits_d;
    marker_q <= marker_d;
    va_q     <= va_d;
    vb_q     <= vb_d;
    vc_q     <= vc_d;
    vd_q     <= vd_d;
  end

  assign digest_word_o = bswap(h_q[oidx_q]);
  assign word_index_o  = oidx_q;
  assign last_o        = (oidx_q == 3'd7);

`ifndef NO_ASSERTIONS
  // Digest words and new message words never overlap.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while digest words pending");

  // The final digest word returns the engine to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last_o) |=> (in_ready_o && wc_q == 4'd0 && cnt_q == '0))
    else $error("engine not cleared after last digest word");

  // Digest words are only shown after a feed-forward step.
  a_emit_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == StFin && word_index_o == 3'd0))
    else $error("digest output started outside feed-forward");
`endif

endmodule
